// ----- rtl/core/lcuw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lcuw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW = 32;
  localparam int DW = 33;
  localparam int PW = 34;
  localparam int LANES = 4;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] clip_start_x;
    logic signed [CW-1:0] clip_start_y;
    logic signed [CW-1:0] clip_end_x;
    logic signed [CW-1:0] clip_end_y;
  } out_t;

  typedef struct packed {
    logic [DW-1:0] qmag;
    logic [DW-1:0] pmag;
    logic          neg;
  } lane_t;

  typedef lane_t [LANES-1:0] lane_arr_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [LANES-1:0]     pzero;
    logic [LANES-1:0]     pneg;
    logic                 reject;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/core/lcuw_edge.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lcuw_edge #(
  parameter int FRAC_BITS = lcuw_pkg::FRAC_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire                      valid_i,
  input  lcuw_pkg::in_t            data_i,
  output logic                     valid_o,
  output lcuw_pkg::lane_arr_t      lanes_o,
  output lcuw_pkg::side_t          side_o
);

  localparam int PW = lcuw_pkg::PW;
  localparam int DW = lcuw_pkg::DW;
  localparam logic signed [PW-1:0] ONE = PW'(1) << FRAC_BITS;

  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] p [lcuw_pkg::LANES];
  logic signed [PW-1:0] q [lcuw_pkg::LANES];
  logic signed [PW-1:0] x1e, y1e;
  lcuw_pkg::lane_arr_t lanes_d, lanes_q;
  lcuw_pkg::side_t     side_d, side_q;
  logic                valid_q;

  always_comb begin
    x1e = PW'(data_i.start_x);
    y1e = PW'(data_i.start_y);
    dx  = DW'(data_i.end_x) - DW'(data_i.start_x);
    dy  = DW'(data_i.end_y) - DW'(data_i.start_y);
    p[0] = -PW'(dx);
    p[1] = PW'(dx);
    p[2] = -PW'(dy);
    p[3] = PW'(dy);
    q[0] = x1e;
    q[1] = ONE - x1e;
    q[2] = y1e;
    q[3] = ONE - y1e;
    side_d.x1 = data_i.start_x;
    side_d.y1 = data_i.start_y;
    side_d.dx = dx;
    side_d.dy = dy;
    for (int k = 0; k < lcuw_pkg::LANES; k++) begin
      lanes_d[k].pmag = p[k][PW-1] ? DW'(-p[k]) : DW'(p[k]);
      lanes_d[k].qmag = q[k][PW-1] ? DW'(-q[k]) : DW'(q[k]);
      lanes_d[k].neg  = p[k][PW-1] ^ q[k][PW-1];
      side_d.pzero[k] = (p[k] == '0);
      side_d.pneg[k]  = p[k][PW-1];
    end
    side_d.reject = |(side_d.pzero & {q[3][PW-1], q[2][PW-1], q[1][PW-1], q[0][PW-1]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
      side_q  <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// ----- rtl/core/lcuw_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lcuw_div #(
  parameter int FRAC_BITS = lcuw_pkg::FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  lcuw_pkg::lane_t              lane_i,
  output logic signed [FRAC_BITS+2:0]  t_o
);

  localparam int NS = FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 3;
  localparam int DW = lcuw_pkg::DW;
  localparam int RW = DW + 1;
  localparam logic [NS-1:0] TWO = NS'(2) << FRAC_BITS;

  logic [RW-1:0] r_q   [NS];
  logic [DW-1:0] d_q   [NS];
  logic [NS-1:0] qb_q  [NS];
  logic          neg_q [NS];
  logic          sat_q [NS];
  logic signed [TW-1:0] t_q;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW-1:0] r_prev, rin, trial, r_d;
    logic [DW-1:0] d_prev;
    logic [NS-1:0] qb_prev, qb_d;
    logic          neg_prev, sat_prev, ge;

    if (s == 0) begin : g_head
      assign r_prev   = RW'(lane_i.qmag);
      assign d_prev   = lane_i.pmag;
      assign qb_prev  = '0;
      assign neg_prev = lane_i.neg;
      assign sat_prev = ({2'b00, lane_i.qmag} >= {lane_i.pmag, 2'b00});
    end else begin : g_tail
      assign r_prev   = r_q[s-1];
      assign d_prev   = d_q[s-1];
      assign qb_prev  = qb_q[s-1];
      assign neg_prev = neg_q[s-1];
      assign sat_prev = sat_q[s-1];
    end

    always_comb begin
      rin   = (s >= 2) ? {r_prev[RW-2:0], 1'b0} : r_prev;
      trial = (s == 0) ? {d_prev, 1'b0} : {1'b0, d_prev};
      ge    = (rin >= trial);
      r_d   = ge ? (rin - trial) : rin;
      qb_d  = qb_prev;
      qb_d[NS-1-s] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= r_d;
        d_q[s]   <= d_prev;
        qb_q[s]  <= qb_d;
        neg_q[s] <= neg_prev;
        sat_q[s] <= sat_prev;
      end
    end
  end

  logic [NS-1:0]        mag;
  logic signed [TW-1:0] t_d;

  always_comb begin
    mag = (sat_q[NS-1] || (qb_q[NS-1] > TWO)) ? TWO : qb_q[NS-1];
    t_d = neg_q[NS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule
`default_nettype wire

// ----- rtl/core/lcuw_clip.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lcuw_clip #(
  parameter int FRAC_BITS = lcuw_pkg::FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire signed [FRAC_BITS+2:0]   t0_i,
  input  wire signed [FRAC_BITS+2:0]   t1_i,
  input  wire signed [FRAC_BITS+2:0]   t2_i,
  input  wire signed [FRAC_BITS+2:0]   t3_i,
  input  lcuw_pkg::side_t              side_i,
  output logic                         valid_o,
  output lcuw_pkg::out_t               data_o
);

  localparam int TW = FRAC_BITS + 3;
  localparam int CW = lcuw_pkg::CW;
  localparam int DW = lcuw_pkg::DW;
  localparam int MW = TW + DW;
  localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  logic signed [TW-1:0] t [lcuw_pkg::LANES];
  logic signed [TW-1:0] lo_d, hi_d, lo_q, hi_q;
  logic                 rej_d, rej_a_q, rej_b_q;
  logic signed [CW-1:0] x1_a_q, y1_a_q, x1_b_q, y1_b_q;
  logic signed [DW-1:0] dx_a_q, dy_a_q;
  logic signed [MW-1:0] psx_q, psy_q, pex_q, pey_q;
  logic signed [MW-1:0] sx, sy, ex, ey;
  logic                 va_q, vb_q, vc_q;
  lcuw_pkg::out_t       out_d, out_q;

  always_comb begin
    t[0] = t0_i;
    t[1] = t1_i;
    t[2] = t2_i;
    t[3] = t3_i;
    lo_d = '0;
    hi_d = ONE;
    for (int k = 0; k < lcuw_pkg::LANES; k++) begin
      if (!side_i.pzero[k]) begin
        if (side_i.pneg[k]) begin
          if (t[k] > lo_d) lo_d = t[k];
        end else begin
          if (t[k] < hi_d) hi_d = t[k];
        end
      end
    end
    rej_d = side_i.reject || (lo_d > hi_d);
  end

  always_comb begin
    sx = psx_q >>> FRAC_BITS;
    sy = psy_q >>> FRAC_BITS;
    ex = pex_q >>> FRAC_BITS;
    ey = pey_q >>> FRAC_BITS;
    if (rej_b_q) begin
      out_d = '0;
    end else begin
      out_d.visible      = 1'b1;
      out_d.clip_start_x = x1_b_q + sx[CW-1:0];
      out_d.clip_start_y = y1_b_q + sy[CW-1:0];
      out_d.clip_end_x   = x1_b_q + ex[CW-1:0];
      out_d.clip_end_y   = y1_b_q + ey[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      rej_a_q <= rej_d;
      x1_a_q  <= side_i.x1;
      y1_a_q  <= side_i.y1;
      dx_a_q  <= side_i.dx;
      dy_a_q  <= side_i.dy;
      psx_q   <= MW'(lo_q) * MW'(dx_a_q);
      psy_q   <= MW'(lo_q) * MW'(dy_a_q);
      pex_q   <= MW'(hi_q) * MW'(dx_a_q);
      pey_q   <= MW'(hi_q) * MW'(dy_a_q);
      rej_b_q <= rej_a_q;
      x1_b_q  <= x1_a_q;
      y1_b_q  <= y1_a_q;
      out_q   <= out_d;
    end
  end

  assign valid_o = vc_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/line_clip_unit_window_core.sv -----
// Results pass the edge register, four quotient pipelines and clip registers; default Q16.16.
// Throughput: one transaction per cycle unless stalled; each quotient stage retires one bit.
// The whole pipeline holds while a result is stalled at the output register.
// Reset is asynchronous and active low; it clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module line_clip_unit_window_core #(
  parameter int FRAC_BITS = lcuw_pkg::FRAC_BITS_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  lcuw_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output lcuw_pkg::out_t  out_data_o
);

  localparam int TW = FRAC_BITS + 3;
  localparam int ND = FRAC_BITS + 3;

  logic                en;
  logic                e_valid;
  lcuw_pkg::lane_arr_t e_lanes;
  lcuw_pkg::side_t     e_side;
  logic signed [TW-1:0] t [lcuw_pkg::LANES];
  lcuw_pkg::side_t     side_q [ND];
  logic [ND-1:0]       vld_q;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  lcuw_edge #(.FRAC_BITS(FRAC_BITS)) u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (e_valid),
    .lanes_o (e_lanes),
    .side_o  (e_side)
  );

  for (genvar k = 0; k < lcuw_pkg::LANES; k++) begin : g_lane
    lcuw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (e_lanes[k]),
      .t_o    (t[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ND-2:0], e_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= e_side;
      for (int s = 1; s < ND; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  lcuw_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[ND-1]),
    .t0_i    (t[0]),
    .t1_i    (t[1]),
    .t2_i    (t[2]),
    .t3_i    (t[3]),
    .side_i  (side_q[ND-1]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- bench/lcuw_clip_checker.sv -----
`timescale 1ns / 1ps
module lcuw_clip_checker #(
  parameter int FRAC_BITS = lcuw_pkg::FRAC_BITS_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  input  wire            in_stall_i,
  input  lcuw_pkg::in_t  in_data_i,
  input  wire            out_valid_i,
  input  wire            out_stall_i,
  input  lcuw_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  localparam longint ONE = longint'(1) << FRAC_BITS;

  lcuw_pkg::out_t clip_queue[$];
  int   fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = clip_queue.size();

  function automatic longint scaled_floor(longint t, longint d);
    longint prod;
    prod = t * d;
    if (prod >= 0) return prod / ONE;
    return -((-prod + ONE - 1) / ONE);
  endfunction

  function automatic lcuw_pkg::out_t clip_segment(lcuw_pkg::in_t seg);
    longint x1, y1, dx, dy, t, t0, t1;
    longint p[4];
    longint q[4];
    bit     ok;
    lcuw_pkg::out_t r;
    x1 = longint'(seg.start_x);
    y1 = longint'(seg.start_y);
    dx = longint'(seg.end_x) - x1;
    dy = longint'(seg.end_y) - y1;
    p[0] = -dx; q[0] = x1;
    p[1] = dx;  q[1] = ONE - x1;
    p[2] = -dy; q[2] = y1;
    p[3] = dy;  q[3] = ONE - y1;
    t0 = 0;
    t1 = ONE;
    ok = 1'b1;
    for (int k = 0; k < 4 && ok; k++) begin
      if (p[k] == 0) begin
        if (q[k] < 0) ok = 1'b0;
      end else begin
        t = (q[k] * ONE) / p[k];
        if (t > 2 * ONE) t = 2 * ONE;
        if (t < -2 * ONE) t = -2 * ONE;
        if (p[k] < 0) begin
          if (t > t0) t0 = t;
        end else begin
          if (t < t1) t1 = t;
        end
        if (t0 > t1) ok = 1'b0;
      end
    end
    r = '0;
    if (ok) begin
      r.visible      = 1'b1;
      r.clip_start_x = 32'(x1 + scaled_floor(t0, dx));
      r.clip_start_y = 32'(y1 + scaled_floor(t0, dy));
      r.clip_end_x   = 32'(x1 + scaled_floor(t1, dx));
      r.clip_end_y   = 32'(y1 + scaled_floor(t1, dy));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    lcuw_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) clip_queue.push_back(clip_segment(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (clip_queue.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = clip_queue.pop_front();
          if (out_data_i.visible != want.visible)
            report_mismatch("visible", out_data_i.visible, want.visible);
          if (out_data_i.clip_start_x != want.clip_start_x)
            report_mismatch("clip_start_x", out_data_i.clip_start_x, want.clip_start_x);
          if (out_data_i.clip_start_y != want.clip_start_y)
            report_mismatch("clip_start_y", out_data_i.clip_start_y, want.clip_start_y);
          if (out_data_i.clip_end_x != want.clip_end_x)
            report_mismatch("clip_end_x", out_data_i.clip_end_x, want.clip_end_x);
          if (out_data_i.clip_end_y != want.clip_end_y)
            report_mismatch("clip_end_y", out_data_i.clip_end_y, want.clip_end_y);
        end
      end
    end
  end
endmodule

// ----- bench/tb_line_clip_unit_window_core.sv -----
`timescale 1ns / 1ps
module tb_line_clip_unit_window_core;

  localparam int     FRAC = lcuw_pkg::FRAC_BITS_DEF;
  localparam int     LATENCY = FRAC + 7;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int     ONE = 1 << FRAC;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lcuw_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lcuw_pkg::out_t out_data;

  int     fail_count;
  int     pending;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_off = 1'b0;
  longint cycles = 0;

  line_clip_unit_window_core #(.FRAC_BITS(FRAC)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  lcuw_clip_checker #(.FRAC_BITS(FRAC)) checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [31:0] coord_value();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($urandom_range(ONE));
      2: return 32'(int'($urandom_range(4 * ONE)) - 2 * ONE);
      3: return 32'(int'($urandom_range(64)) - 32 + (($urandom_range(1)) ? ONE : 0));
      4: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(int'($urandom_range(ONE)) - ONE / 2) * 3;
    endcase
  endfunction

  task automatic send_segment(logic [31:0] x1, logic [31:0] y1,
                              logic [31:0] x2, logic [31:0] y2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{start_x: x1, start_y: y1, end_x: x2, end_y: y2};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(int n);
    logic [31:0] x1, y1;
    for (int i = 0; i < n; i++) begin
      x1 = coord_value();
      y1 = coord_value();
      case ($urandom_range(3))
        0: send_segment(x1, y1, x1, coord_value());
        1: send_segment(x1, y1, coord_value(), y1);
        default: send_segment(x1, y1, coord_value(), coord_value());
      endcase
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_segment(0, 0, ONE, ONE);
    send_segment(-ONE, ONE / 2, 2 * ONE, ONE / 2);
    send_segment(ONE / 2, -ONE, ONE / 2, 2 * ONE);
    send_segment(-ONE, -ONE, -ONE, 2 * ONE);
    send_segment(2 * ONE, ONE / 2, 2 * ONE, ONE);
    send_segment(ONE / 2, -ONE, ONE, -ONE);
    send_segment(ONE / 2, 3 * ONE, ONE, 3 * ONE);
    send_segment(-ONE, ONE / 2, ONE / 2, 3 * ONE);
    send_segment(3 * ONE / 2, -ONE, 3 * ONE, ONE / 2);
    send_segment(ONE / 2, ONE / 2, ONE / 2, ONE / 2);
    send_segment(ONE, ONE, ONE, ONE);
    send_segment(0, 0, 0, 0);
    send_segment(ONE + 1, ONE / 2, ONE + 1, ONE / 2);
    send_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_segment(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_segment(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_segment(32'hffffffff, 32'hffffffff, ONE + 1, ONE + 1);
    send_segment(-ONE, 0, 0, ONE);
    send_segment(ONE / 4, ONE / 4, 3 * ONE / 4, 3 * ONE / 4);
    send_segment(-7, 5, ONE + 3, ONE - 9);
    drain_results();

    send_random(130);
    send_idle_pct = 62;
    send_random(130);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    send_random(130);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    send_random(70);
    drain_results();
    repeat ($urandom_range(2 * LATENCY)) @(posedge clk);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (4 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(70);
    join
    send_random(30);
    drain_results();

    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- line_clip_unit_window_core.f -----
rtl/core/lcuw_pkg.sv
rtl/core/lcuw_edge.sv
rtl/core/lcuw_div.sv
rtl/core/lcuw_clip.sv
rtl/core/line_clip_unit_window_core.sv
bench/lcuw_clip_checker.sv
bench/tb_line_clip_unit_window_core.sv
